[hw/rtl/constrained_union_find_splitter_unit_assert.svh]
// Assertion macros shared by the splitter RTL.
// Expects a clock aclk and an active-low reset aresetn in the using scope.
`ifndef CONSTRAINED_UNION_FIND_SPLITTER_UNIT_ASSERT_SVH
`define CONSTRAINED_UNION_FIND_SPLITTER_UNIT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define CUFS_ASSERT_NOW(lbl, trig, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error("splitter assertion failed");

// condition holds in the cycle after the trigger
`define CUFS_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("splitter assertion failed");

`endif

[hw/rtl/cufs_pkg.sv]
// Shared types and constants of the union-find splitter.
// No dependencies.
package cufs_pkg;

    localparam int DEF_MAX_READS   = 1024;
    localparam int DEF_MAX_ANCHORS = 4096;

    localparam int         RANK_W   = 4;
    localparam logic [3:0] RANK_MAX = 4'd15;

    localparam logic REG_READ_COUNT   = 1'b0;
    localparam logic REG_ANCHOR_COUNT = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_OFFER = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_DISPATCH, ST_CLEAR, ST_MCHK, ST_FSTART, ST_F_RD,
        ST_F_EVAL, ST_C_RD, ST_C_EVAL, ST_DECIDE, ST_U_RD, ST_U_EVAL, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE, DP_CAPTURE, DP_CLR, DP_LOAD, DP_MREAD, DP_FSTART, DP_F_RD,
        DP_F_EVAL, DP_C_RD, DP_C_EVAL, DP_U_RD, DP_U_EVAL, DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] sel;
        logic       set_err;
        logic       clr_cut;
    } dp_ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic clr_last;
        logic load_bad;
        logic offer_bad;
        logic mirror_bad;
        logic query_bad;
        logic f_hit;
        logic c_last;
        logic root_eq;
        logic join_ok;
    } dp_stat_t;

endpackage

[hw/rtl/cufs_datapath.sv]
// Datapath of the splitter: config registers, parent/rank/mirror memories,
// find and union datapath, result registers. Depends on cufs_pkg.
`include "constrained_union_find_splitter_unit_assert.svh"
module cufs_datapath
    import cufs_pkg::*;
#(
    parameter int MAX_READS   = DEF_MAX_READS,
    parameter int MAX_ANCHORS = DEF_MAX_ANCHORS,
    localparam int V   = MAX_READS + MAX_ANCHORS,
    localparam int VW  = $clog2(V),
    localparam int RW  = $clog2(MAX_READS),
    localparam int AW  = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1,
    localparam int RCW = $clog2(MAX_READS + 1),
    localparam int ACW = $clog2(MAX_ANCHORS + 1),
    localparam int CDW = (RCW > ACW) ? RCW : ACW
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [CDW-1:0] cfg_data,
    input  logic [1:0]     s_command,
    input  logic [RW-1:0]  s_read_index,
    input  logic [AW-1:0]  s_anchor_index,
    input  logic [AW-1:0]  s_mirror_anchor,
    input  logic [VW-1:0]  s_vertex_index,
    output logic           m_cut,
    output logic [VW-1:0]  m_root,
    output logic           m_error,
    input  dp_ctrl_t       ctrl,
    output dp_stat_t       stat
);

    logic [RCW-1:0] read_count_reg;
    logic [ACW-1:0] anchor_count_reg;

    logic [VW-1:0]     parent_mem [V];
    logic [RANK_W-1:0] rank_mem   [V];
    logic [AW-1:0]     mirror_mem [MAX_ANCHORS];

    cmd_t          cmd_reg, cmd_next;
    logic [RW-1:0] r_reg, r_next;
    logic [AW-1:0] a_reg, a_next;
    logic [AW-1:0] m_reg, m_next;
    logic [VW-1:0] v_reg, v_next;
    logic [VW-1:0] cur_reg, cur_next;
    logic [VW-1:0] vstart_reg, vstart_next;
    logic [VW-1:0] froot_reg, froot_next;
    logic [VW-1:0] cr_reg, cr_next, crm_reg, crm_next;
    logic [VW-1:0] ca_reg, ca_next, cam_reg, cam_next;
    logic [VW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          cut_reg, cut_next, err_reg, err_next;
    logic          out_cut_reg, out_err_reg;
    logic [VW-1:0] out_root_reg;

    logic [VW-1:0]     p_rdata_reg;
    logic [RANK_W-1:0] rk_x_reg, rk_y_reg;
    logic [AW-1:0]     am_reg;

    logic              p_we, rk_we;
    logic [VW-1:0]     p_waddr, p_wdata, rk_waddr;
    logic [RANK_W-1:0] rk_wdata;

    logic [RCW-1:0] rc_even, nr;
    logic [ACW-1:0] na;
    logic [VW-1:0]  start_v, ux, uy;
    logic           hit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_count_reg   <= RCW'(2);
            anchor_count_reg <= ACW'(1);
        end else if (cfg_valid) begin
            if (cfg_index == REG_READ_COUNT) begin
                read_count_reg <= cfg_data[RCW-1:0];
            end else begin
                anchor_count_reg <= cfg_data[ACW-1:0];
            end
        end
    end

    always_comb begin
        rc_even = {read_count_reg[RCW-1:1], 1'b0};
        if (rc_even < RCW'(2)) begin
            nr = RCW'(2);
        end else if (rc_even > RCW'(MAX_READS)) begin
            nr = RCW'(MAX_READS) & ~RCW'(1);
        end else begin
            nr = rc_even;
        end
        if (anchor_count_reg == '0) begin
            na = ACW'(1);
        end else if (anchor_count_reg > ACW'(MAX_ANCHORS)) begin
            na = ACW'(MAX_ANCHORS);
        end else begin
            na = anchor_count_reg;
        end
    end

    assign hit = (p_rdata_reg == cur_reg);
    assign ux  = ctrl.sel[0] ? crm_reg : cr_reg;
    assign uy  = ctrl.sel[0] ? cam_reg : ca_reg;

    always_comb begin
        case (ctrl.sel)
            2'd0:    start_v = (cmd_reg == CMD_QUERY) ? v_reg : VW'(r_reg);
            2'd1:    start_v = VW'(r_reg ^ RW'(1));
            2'd2:    start_v = VW'(nr) + VW'(a_reg);
            default: start_v = VW'(nr) + VW'(am_reg);
        endcase
    end

    always_comb begin
        stat.cmd        = cmd_reg;
        stat.clr_last   = (clr_cnt_reg == VW'(V - 1));
        stat.load_bad   = (ACW'(a_reg) >= na) || (ACW'(m_reg) >= na);
        stat.offer_bad  = (RCW'(r_reg) >= nr) || (ACW'(a_reg) >= na);
        stat.mirror_bad = (ACW'(am_reg) >= na);
        stat.query_bad  = ((VW+1)'(v_reg) >= ((VW+1)'(nr) + (VW+1)'(na)));
        stat.f_hit      = hit;
        stat.c_last     = (cur_reg == froot_reg);
        stat.root_eq    = (cr_reg == crm_reg);
        stat.join_ok    = (cr_reg != cam_reg) && (crm_reg != ca_reg) && (ca_reg != cam_reg);
    end

    always_comb begin
        cmd_next     = cmd_reg;
        r_next       = r_reg;
        a_next       = a_reg;
        m_next       = m_reg;
        v_next       = v_reg;
        cur_next     = cur_reg;
        vstart_next  = vstart_reg;
        froot_next   = froot_reg;
        cr_next      = cr_reg;
        crm_next     = crm_reg;
        ca_next      = ca_reg;
        cam_next     = cam_reg;
        clr_cnt_next = clr_cnt_reg;
        cut_next     = cut_reg && !ctrl.clr_cut;
        err_next     = err_reg || ctrl.set_err;
        p_we         = 1'b0;
        p_waddr      = cur_reg;
        p_wdata      = froot_reg;
        rk_we        = 1'b0;
        rk_waddr     = uy;
        rk_wdata     = rk_y_reg + RANK_W'(1);
        case (ctrl.op)
            DP_CAPTURE: begin
                cmd_next = cmd_t'(s_command);
                r_next   = s_read_index;
                a_next   = s_anchor_index;
                m_next   = s_mirror_anchor;
                v_next   = s_vertex_index;
                cut_next = (cmd_t'(s_command) == CMD_OFFER);
                err_next = 1'b0;
            end
            DP_CLR: begin
                p_we         = 1'b1;
                p_waddr      = clr_cnt_reg;
                p_wdata      = clr_cnt_reg;
                rk_we        = 1'b1;
                rk_waddr     = clr_cnt_reg;
                rk_wdata     = '0;
                clr_cnt_next = stat.clr_last ? '0 : clr_cnt_reg + VW'(1);
            end
            DP_FSTART: begin
                cur_next    = start_v;
                vstart_next = start_v;
            end
            DP_F_EVAL: begin
                if (hit) begin
                    froot_next = cur_reg;
                    cur_next   = vstart_reg;
                    case (ctrl.sel)
                        2'd0:    cr_next  = cur_reg;
                        2'd1:    crm_next = cur_reg;
                        2'd2:    ca_next  = cur_reg;
                        default: cam_next = cur_reg;
                    endcase
                end else begin
                    cur_next = p_rdata_reg;
                end
            end
            DP_C_EVAL: begin
                p_we     = 1'b1;
                cur_next = p_rdata_reg;
            end
            DP_U_EVAL: begin
                if (ux != uy) begin
                    p_we = 1'b1;
                    if (rk_x_reg > rk_y_reg) begin
                        p_waddr = uy;
                        p_wdata = ux;
                    end else begin
                        p_waddr = ux;
                        p_wdata = uy;
                        rk_we   = (rk_x_reg == rk_y_reg) && (rk_y_reg != RANK_MAX);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        r_reg      <= r_next;
        a_reg      <= a_next;
        m_reg      <= m_next;
        v_reg      <= v_next;
        cur_reg    <= cur_next;
        vstart_reg <= vstart_next;
        froot_reg  <= froot_next;
        cr_reg     <= cr_next;
        crm_reg    <= crm_next;
        ca_reg     <= ca_next;
        cam_reg    <= cam_next;
        cut_reg    <= cut_next;
        err_reg    <= err_next;
        if (ctrl.op == DP_OUT) begin
            out_cut_reg  <= cut_reg;
            out_err_reg  <= err_reg;
            out_root_reg <= (cmd_reg == CMD_QUERY && !err_reg) ? cr_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            parent_mem[p_waddr] <= p_wdata;
        end
        if (ctrl.op == DP_F_RD || ctrl.op == DP_C_RD) begin
            p_rdata_reg <= parent_mem[cur_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (rk_we) begin
            rank_mem[rk_waddr] <= rk_wdata;
        end
        if (ctrl.op == DP_U_RD) begin
            rk_x_reg <= rank_mem[ux];
            rk_y_reg <= rank_mem[uy];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.op == DP_LOAD && !stat.load_bad) begin
            mirror_mem[a_reg] <= m_reg;
        end
        if (ctrl.op == DP_MREAD) begin
            am_reg <= mirror_mem[a_reg];
        end
    end

    assign m_cut   = out_cut_reg;
    assign m_root  = out_root_reg;
    assign m_error = out_err_reg;

    `CUFS_ASSERT_NEXT(a_froot_capture, ctrl.op == DP_F_EVAL && hit, froot_reg == $past(cur_reg))
    `CUFS_ASSERT_NEXT(a_clr_hold, ctrl.op != DP_CLR, $stable(clr_cnt_reg))
    `CUFS_ASSERT_NOW(a_union_writes, ctrl.op == DP_U_EVAL && ux != uy, p_we)

endmodule

[hw/rtl/cufs_ctrl.sv]
// Controller state machine of the splitter: sequences clear sweep, finds,
// unions and result transfer. Depends on cufs_pkg.
`include "constrained_union_find_splitter_unit_assert.svh"
module cufs_ctrl
    import cufs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output dp_ctrl_t ctrl,
    input  dp_stat_t stat
);

    state_t     state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            sel_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        ctrl         = '{op: DP_NONE, sel: sel_reg, set_err: 1'b0, clr_cut: 1'b0};
        unique case (state_reg)
            ST_INIT: begin
                ctrl.op = DP_CLR;
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.op    = DP_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                sel_next = '0;
                unique case (stat.cmd)
                    CMD_LOAD: begin
                        ctrl.op      = DP_LOAD;
                        ctrl.set_err = stat.load_bad;
                        state_next   = ST_OUT;
                    end
                    CMD_CLEAR: state_next = ST_CLEAR;
                    CMD_OFFER: begin
                        if (stat.offer_bad) begin
                            ctrl.set_err = 1'b1;
                            state_next   = ST_OUT;
                        end else begin
                            ctrl.op    = DP_MREAD;
                            state_next = ST_MCHK;
                        end
                    end
                    default: begin
                        if (stat.query_bad) begin
                            ctrl.set_err = 1'b1;
                            state_next   = ST_OUT;
                        end else begin
                            state_next = ST_FSTART;
                        end
                    end
                endcase
            end
            ST_CLEAR: begin
                ctrl.op = DP_CLR;
                if (stat.clr_last) state_next = ST_OUT;
            end
            ST_MCHK: begin
                if (stat.mirror_bad) begin
                    ctrl.set_err = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    state_next = ST_FSTART;
                end
            end
            ST_FSTART: begin
                ctrl.op    = DP_FSTART;
                state_next = ST_F_RD;
            end
            ST_F_RD: begin
                ctrl.op    = DP_F_RD;
                state_next = ST_F_EVAL;
            end
            ST_F_EVAL: begin
                ctrl.op    = DP_F_EVAL;
                state_next = stat.f_hit ? ST_C_RD : ST_F_RD;
            end
            ST_C_RD: begin
                ctrl.op    = DP_C_RD;
                state_next = ST_C_EVAL;
            end
            ST_C_EVAL: begin
                ctrl.op = DP_C_EVAL;
                if (!stat.c_last) begin
                    state_next = ST_C_RD;
                end else if (stat.cmd == CMD_QUERY) begin
                    state_next = ST_OUT;
                end else if (sel_reg == 2'd3) begin
                    state_next = ST_DECIDE;
                end else begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_FSTART;
                end
            end
            ST_DECIDE: begin
                sel_next = '0;
                if (stat.root_eq) begin
                    ctrl.set_err = 1'b1;
                    state_next   = ST_OUT;
                end else if (stat.join_ok) begin
                    state_next = ST_U_RD;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_U_RD: begin
                ctrl.op    = DP_U_RD;
                state_next = ST_U_EVAL;
            end
            ST_U_EVAL: begin
                ctrl.op = DP_U_EVAL;
                if (!sel_reg[0]) begin
                    sel_next   = 2'd1;
                    state_next = ST_U_RD;
                end else begin
                    ctrl.clr_cut = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    ctrl.op      = DP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    assign m_valid = m_valid_reg;

    `CUFS_ASSERT_NEXT(a_busy_after_take, s_valid && s_ready, !s_ready)
    `CUFS_ASSERT_NOW(a_out_needs_room, ctrl.op == DP_OUT, !m_valid_reg || m_ready)

endmodule

[hw/rtl/constrained_union_find_splitter_unit.sv]
// Constrained union-find splitter, top level.
// Channels: s_* commands in (valid/ready), m_* one result per command out,
// cfg_* register writes (index 0 read_count, index 1 anchor_count).
// One command at a time; s_ready is high only while the engine is idle.
// A load writes one mirror table entry, a clear sweeps all V vertices (V =
// MAX_READS + MAX_ANCHORS), a query runs one find, and an offer runs up to
// four finds and two unions. The pace is set by the single-read parent
// memory: each hop of a find and each path compression write takes its own
// read and evaluate state.
// The result sits in an output register; the next command is taken while it
// waits, and the engine holds its result when m_ready stays low.
// After reset a clearing pass makes every vertex its own set with rank 0;
// no command is accepted during it, config writes are taken.
// Config writes are expected only while the engine is idle.
module constrained_union_find_splitter_unit
    import cufs_pkg::*;
#(
    parameter int MAX_READS   = DEF_MAX_READS,
    parameter int MAX_ANCHORS = DEF_MAX_ANCHORS,
    localparam int V   = MAX_READS + MAX_ANCHORS,
    localparam int VW  = $clog2(V),
    localparam int RW  = $clog2(MAX_READS),
    localparam int AW  = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1,
    localparam int RCW = $clog2(MAX_READS + 1),
    localparam int ACW = $clog2(MAX_ANCHORS + 1),
    localparam int CDW = (RCW > ACW) ? RCW : ACW
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [CDW-1:0] cfg_data,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     s_command,
    input  logic [RW-1:0]  s_read_index,
    input  logic [AW-1:0]  s_anchor_index,
    input  logic [AW-1:0]  s_mirror_anchor,
    input  logic [VW-1:0]  s_vertex_index,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_cut,
    output logic [VW-1:0]  m_root,
    output logic           m_error
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    cufs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl),
        .stat    (stat)
    );

    cufs_datapath #(
        .MAX_READS   (MAX_READS),
        .MAX_ANCHORS (MAX_ANCHORS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_command       (s_command),
        .s_read_index    (s_read_index),
        .s_anchor_index  (s_anchor_index),
        .s_mirror_anchor (s_mirror_anchor),
        .s_vertex_index  (s_vertex_index),
        .m_cut           (m_cut),
        .m_root          (m_root),
        .m_error         (m_error),
        .ctrl            (ctrl),
        .stat            (stat)
    );

endmodule

[bench/cufs_scoreboard.sv]
// Result checker for the union-find splitter: tracks the register writes and
// commands it sees, predicts each result and compares it with the next one.
// Depends on cufs_pkg for the command and register codes.
module cufs_scoreboard
    import cufs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [9:0]  s_read_index,
    input  logic [11:0] s_anchor_index,
    input  logic [11:0] s_mirror_anchor,
    input  logic [12:0] s_vertex_index,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_cut,
    input  logic [12:0] m_root,
    input  logic        m_error,
    output int          fail_count,
    output int          pending
);

    localparam int NREADS   = 1024;
    localparam int NANCHORS = 4096;
    localparam int NVERT    = NREADS + NANCHORS;

    typedef struct packed {
        logic        cut;
        logic [12:0] root;
        logic        error;
    } verdict_t;

    logic [12:0] parent_mem [NVERT];
    logic [3:0]  rank_mem   [NVERT];
    logic [11:0] mirror_mem [NANCHORS];
    logic [10:0] read_reg;
    logic [12:0] anchor_reg;
    verdict_t    expected_q [$];

    function automatic int active_reads();
        int r;
        r = read_reg & 11'h7FE;
        if (r < 2) r = 2;
        if (r > NREADS) r = NREADS;
        return r;
    endfunction

    function automatic int active_anchors();
        int a;
        a = anchor_reg;
        if (a < 1) a = 1;
        if (a > NANCHORS) a = NANCHORS;
        return a;
    endfunction

    function automatic void reset_sets();
        for (int i = 0; i < NVERT; i++) begin
            parent_mem[i] = i[12:0];
            rank_mem[i] = '0;
        end
    endfunction

    function automatic int root_of(int v);
        int top;
        int nxt;
        top = v;
        while (parent_mem[top] != top) top = parent_mem[top];
        while (v != top) begin
            nxt = parent_mem[v];
            parent_mem[v] = top[12:0];
            v = nxt;
        end
        return top;
    endfunction

    function automatic void merge(int x, int y);
        int rx;
        int ry;
        rx = root_of(x);
        ry = root_of(y);
        if (rx == ry) return;
        if (rank_mem[rx] > rank_mem[ry]) begin
            parent_mem[ry] = rx[12:0];
        end else begin
            parent_mem[rx] = ry[12:0];
            if (rank_mem[rx] == rank_mem[ry] && rank_mem[ry] != RANK_MAX)
                rank_mem[ry] = rank_mem[ry] + 4'd1;
        end
    endfunction

    function automatic verdict_t predict(logic [1:0] op, int r, int a, int m, int v);
        verdict_t res;
        int nr;
        int na;
        int am;
        int cr;
        int crm;
        int ca;
        int cam;
        res = '0;
        nr = active_reads();
        na = active_anchors();
        case (op)
            CMD_LOAD: begin
                if (a < na && m < na) mirror_mem[a] = m[11:0];
                else res.error = 1'b1;
            end
            CMD_CLEAR: reset_sets();
            CMD_OFFER: begin
                res.cut = 1'b1;
                if (r >= nr || a >= na) begin
                    res.error = 1'b1;
                end else begin
                    am = mirror_mem[a];
                    if (am >= na) begin
                        res.error = 1'b1;
                    end else begin
                        cr  = root_of(r);
                        crm = root_of(r ^ 1);
                        ca  = root_of(nr + a);
                        cam = root_of(nr + am);
                        if (cr == crm) begin
                            res.error = 1'b1;
                        end else if (cr != cam && crm != ca && ca != cam) begin
                            merge(r, nr + a);
                            merge(r ^ 1, nr + am);
                            res.cut = 1'b0;
                            if (root_of(r) == root_of(r ^ 1)) res.error = 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (v < nr + na) res.root = 13'(root_of(v));
                else res.error = 1'b1;
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        verdict_t want;
        verdict_t seen;
        verdict_t fresh;
        if (!aresetn) begin
            reset_sets();
            for (int i = 0; i < NANCHORS; i++) mirror_mem[i] = '0;
            read_reg = 11'd2;
            anchor_reg = 13'd1;
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_READ_COUNT) read_reg = cfg_data[10:0];
                else anchor_reg = cfg_data;
            end
            if (s_valid && s_ready) begin
                fresh = predict(s_command, s_read_index, s_anchor_index,
                                s_mirror_anchor, s_vertex_index);
                expected_q.insert(expected_q.size(), fresh);
            end
            if (m_valid && m_ready) begin
                seen = '{m_cut, m_root, m_error};
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: cut=%0b root=%0d error=%0b",
                                 m_cut, m_root, m_error);
                end else begin
                    want = expected_q.pop_front();
                    if (want != seen) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected cut=%0b root=%0d error=%0b, %s",
                                     want.cut, want.root, want.error,
                                     $sformatf("got cut=%0b root=%0d error=%0b",
                                               seen.cut, seen.root, seen.error));
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

[bench/tb_constrained_union_find_splitter_unit.sv]
// Testbench top for the union-find splitter: clock, reset, command and
// register stimulus with random idling, and the final verdict.
// Depends on cufs_pkg, the splitter RTL and cufs_scoreboard.
module tb_constrained_union_find_splitter_unit;
    import cufs_pkg::*;

    localparam int LIMIT = 2000000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [12:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [9:0]  s_read_index;
    logic [11:0] s_anchor_index;
    logic [11:0] s_mirror_anchor;
    logic [12:0] s_vertex_index;
    logic        m_valid;
    logic        m_ready;
    logic        m_cut;
    logic [12:0] m_root;
    logic        m_error;
    int          fail_count;
    int          pending;
    int          cycles;
    int          burst_left;
    int          nr;
    int          na;
    bit          slot_loaded [4096];
    int          anchor_pool [$];

    constrained_union_find_splitter_unit dut (.*);

    cufs_scoreboard checker_i (.*);

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    int stall_mode;
    int stall_left;
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 2) == 0);
            default: m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic send(logic [1:0] op, int r, int a, int m, int v);
        s_valid = 1'b1;
        s_command = op;
        s_read_index = r[9:0];
        s_anchor_index = a[11:0];
        s_mirror_anchor = m[11:0];
        s_vertex_index = v[12:0];
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (op == CMD_LOAD && a < na && m < na) slot_loaded[a] = 1'b1;
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
        end else begin
            burst_left--;
        end
    endtask

    task automatic write_reg(logic idx, int val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val[12:0];
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_sizes(int rc, int ac);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        write_reg(REG_READ_COUNT, rc);
        write_reg(REG_ANCHOR_COUNT, ac);
        nr = rc & 'h7FE;
        if (nr < 2) nr = 2;
        if (nr > 1024) nr = 1024;
        na = ac & 'h1FFF;
        if (na < 1) na = 1;
        if (na > 4096) na = 4096;
    endtask

    // anchor that never reaches an unloaded table slot
    function automatic int safe_anchor(int a);
        if (a < na && !slot_loaded[a])
            return anchor_pool.size() ? anchor_pool[$urandom_range(0, anchor_pool.size()-1)]
                                      : na;
        return a;
    endfunction

    task automatic run_phase(int rc, int ac, int count, bit do_clear);
        int base;
        int k;
        int rbase;
        int rspan;
        int a;
        int sel;
        set_sizes(rc, ac);
        if (do_clear) send(CMD_CLEAR, 0, 0, 0, 0);
        anchor_pool.delete();
        k = (na < 40) ? na : $urandom_range(4, 40);
        base = $urandom_range(0, na - k);
        for (int i = 0; i < k; i++) begin
            a = base + i;
            if ($urandom_range(0, 7) == 0) send(CMD_LOAD, 0, a, $urandom_range(base, base+k-1), 0);
            else if ((a ^ 1) >= base && (a ^ 1) < base + k) send(CMD_LOAD, 0, a, a ^ 1, 0);
            else send(CMD_LOAD, 0, a, a, 0);
            if (slot_loaded[a]) anchor_pool.insert(anchor_pool.size(), a);
        end
        rspan = (nr < 32) ? nr : 32;
        rbase = $urandom_range(0, (nr - rspan) / 2) * 2;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 60 && anchor_pool.size() != 0)
                send(CMD_OFFER, rbase + $urandom_range(0, rspan-1),
                     anchor_pool[$urandom_range(0, anchor_pool.size()-1)], 0, 0);
            else if (sel < 78)
                send(CMD_QUERY, 0, 0, 0, ($urandom_range(0, 1) ? rbase + $urandom_range(0, rspan-1)
                                                              : nr + base + $urandom_range(0, k-1)));
            else if (sel < 83)
                send(CMD_QUERY, 0, 0, 0, $urandom_range(0, 8191));
            else if (sel < 88)
                send(CMD_LOAD, 0, $urandom_range(0, 4095), $urandom_range(0, 4095), 0);
            else if (sel < 90)
                send(CMD_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 8191));
            else
                send(CMD_OFFER, $urandom_range(0, 1023), safe_anchor($urandom_range(0, 4095)),
                     $urandom_range(0, 4095), $urandom_range(0, 8191));
        end
    endtask

    initial begin
        cycles = 0;
        burst_left = 0;
        stall_left = 0;
        stall_mode = 0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_READ_COUNT;
        cfg_data = '0;
        s_valid = 1'b0;
        s_command = CMD_LOAD;
        s_read_index = '0;
        s_anchor_index = '0;
        s_mirror_anchor = '0;
        s_vertex_index = '0;
        m_ready = 1'b0;
        nr = 2;
        na = 1;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        set_sizes(4, 4);
        send(CMD_QUERY, 0, 0, 0, 0);
        send(CMD_QUERY, 0, 0, 0, 8);
        send(CMD_QUERY, 0, 0, 0, 8191);
        send(CMD_LOAD, 0, 0, 1, 0);
        send(CMD_LOAD, 0, 1, 0, 0);
        send(CMD_LOAD, 0, 2, 2, 0);
        send(CMD_LOAD, 0, 3, 3, 0);
        send(CMD_LOAD, 0, 4, 0, 0);
        send(CMD_LOAD, 0, 0, 4, 0);
        send(CMD_OFFER, 0, 0, 0, 0);
        send(CMD_OFFER, 1, 1, 0, 0);
        send(CMD_OFFER, 0, 1, 0, 0);
        send(CMD_OFFER, 2, 2, 0, 0);
        send(CMD_OFFER, 2, 0, 0, 0);
        send(CMD_OFFER, 2, 1, 0, 0);
        send(CMD_OFFER, 4, 0, 0, 0);
        send(CMD_OFFER, 0, 4, 0, 0);
        send(CMD_QUERY, 0, 0, 0, 7);
        send(CMD_QUERY, 0, 0, 0, 2);
        // renumber without a clear, then shrink the anchors under loaded mirrors
        set_sizes(2, 2);
        send(CMD_OFFER, 0, 0, 0, 0);
        send(CMD_OFFER, 0, 2, 0, 0);
        send(CMD_QUERY, 0, 0, 0, 3);
        send(CMD_CLEAR, 0, 0, 0, 0);
        send(CMD_QUERY, 0, 0, 0, 3);

        run_phase(2, 1, 65, 1);
        run_phase(6, 4, 75, 1);
        run_phase(1024, 4096, 85, 1);
        run_phase(7, 0, 65, 0);
        run_phase(2047, 8191, 85, 1);
        run_phase(32, 16, 85, 1);
        run_phase(1025, 4097, 75, 0);
        run_phase(200, 300, 85, 1);
        run_phase(12, 10, 75, 0);
        run_phase(512, 1024, 85, 1);

        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
